// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every clock edge outside reset
`define PMBE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define PMBE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PMBE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pmbe_pkg.sv =====
// types, constants and helpers of the pixel mask bitmap engine
// no dependencies
`timescale 1ns / 1ps
package pmbe_pkg;
   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLS    = 256;
   localparam int WORD_BITS   = 32;
   localparam int MASK_DEPTH  = (MAX_ROWS * MAX_COLS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_BITS   = $clog2(MASK_DEPTH);
   localparam int PIX_BITS    = $clog2(MAX_ROWS * MAX_COLS);
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int COL_BITS    = $clog2(MAX_COLS);
   localparam int DIM_BITS    = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_NUM_ROWS = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_NUM_COLS = 1'd1;

   localparam logic [1:0] COP_ASSIGN = 2'd0;
   localparam logic [1:0] COP_AND    = 2'd1;
   localparam logic [1:0] COP_OR     = 2'd2;
   localparam logic [1:0] COP_XOR    = 2'd3;

   typedef enum logic [3:0] {
      ACT_CLEAR_ALL = 4'd0,
      ACT_FILL_ALL  = 4'd1,
      ACT_CLR_PIX   = 4'd2,
      ACT_SET_PIX   = 4'd3,
      ACT_INVERT    = 4'd4,
      ACT_RECOMPUTE = 4'd5,
      ACT_COMBINE   = 4'd6,
      ACT_ADD_RECT  = 4'd7,
      ACT_READ      = 4'd8
   } action_type;

   typedef enum logic [3:0] {
      BK_NONE, BK_CLEAR, BK_FILL, BK_INVERT, BK_RECOMP,
      BK_PIXCLR, BK_PIXSET, BK_COMBINE, BK_RECT
   } bop_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  rows;
      logic [DIM_BITS-1:0]  cols;
      logic [ADDR_BITS:0]   words;
   } cfg_type;

   typedef struct packed {
      bop_type               op;
      logic                  recomp;
      logic                  ign;
      logic                  word_in;
      logic                  pix_in;
      logic                  row_in;
      logic                  col_in;
      logic [7:0]            prow;
      logic [7:0]            pcol;
      logic [8:0]            rh;
      logic [8:0]            rw;
      logic [PIX_BITS-1:0]   k;
      logic [ADDR_BITS-1:0]  widx;
      logic [WORD_BITS-1:0]  wdata;
      logic [1:0]            cop;
   } cmd_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] lim);
      if (v == '0) return DIM_BITS'(1);
      if (v > lim) return lim;
      return v;
   endfunction
endpackage

// ===== rtl/core/pmbe_if.sv =====
// request and response channel interfaces
// depends on pmbe_pkg
`timescale 1ns / 1ps
interface pmbe_req_if;
   import pmbe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [3:0]            action;
   logic [7:0]            pixel_row;
   logic [7:0]            pixel_col;
   logic [8:0]            rect_height;
   logic [8:0]            rect_width;
   logic [ADDR_BITS-1:0]  word_index;
   logic [WORD_BITS-1:0]  word_data;
   logic [1:0]            combine_op;
   logic [8:0]            operand_rows;
   logic [8:0]            operand_cols;
   logic                  last;
   modport source (output valid, action, pixel_row, pixel_col, rect_height, rect_width,
                   word_index, word_data, combine_op, operand_rows, operand_cols, last,
                   input ready);
   modport sink (input valid, action, pixel_row, pixel_col, rect_height, rect_width,
                 word_index, word_data, combine_op, operand_rows, operand_cols, last,
                 output ready);
endinterface

interface pmbe_rsp_if;
   import pmbe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WORD_BITS-1:0]  read_word;
   logic                  pixel_bit;
   logic                  row_any;
   logic                  col_any;
   logic                  ignored;
   modport source (output valid, read_word, pixel_bit, row_any, col_any, ignored,
                   input ready);
   modport sink (input valid, read_word, pixel_bit, row_any, col_any, ignored,
                 output ready);
endinterface

// ===== rtl/core/pmbe_front.sv =====
// front end: size registers, request decode and range checks
// depends on pmbe_pkg and pmbe_if
`timescale 1ns / 1ps
module pmbe_front (
   input  logic                             clock,
   input  logic                             reset,
   pmbe_req_if.sink                         req_ch,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pmbe_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [pmbe_pkg::DIM_BITS-1:0]    csr_data,
   input  logic                             init_done,
   input  logic                             q_full,
   output logic                             push,
   output pmbe_pkg::cmd_type                push_cmd,
   output pmbe_pkg::cfg_type                cfg
);
   import pmbe_pkg::*;

   localparam logic [DIM_BITS-1:0] ROWS_LIM = DIM_BITS'(MAX_ROWS);
   localparam logic [DIM_BITS-1:0] COLS_LIM = DIM_BITS'(MAX_COLS);

   logic [DIM_BITS-1:0]   rows_ff, cols_ff;
   logic [2*DIM_BITS-1:0] area;
   logic                  size_ok, rect_fit, rect_empty;
   cmd_type               c;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_LIM;
         cols_ff <= COLS_LIM;
      end else if (csr_valid) begin
         if (csr_index == REG_NUM_ROWS) rows_ff <= clamp_dim(csr_data, ROWS_LIM);
         if (csr_index == REG_NUM_COLS) cols_ff <= clamp_dim(csr_data, COLS_LIM);
      end
   end

   assign area       = rows_ff * cols_ff;
   assign cfg.rows   = rows_ff;
   assign cfg.cols   = cols_ff;
   assign cfg.words  = (ADDR_BITS + 1)'((area + (2*DIM_BITS)'(WORD_BITS - 1)) >> 5);

   assign size_ok    = (req_ch.operand_rows == rows_ff) && (req_ch.operand_cols == cols_ff);
   assign rect_fit   = ((10'(req_ch.pixel_row) + 10'(req_ch.rect_height)) <= 10'(rows_ff)) &&
                       ((10'(req_ch.pixel_col) + 10'(req_ch.rect_width)) <= 10'(cols_ff));
   assign rect_empty = (req_ch.rect_height == '0) || (req_ch.rect_width == '0);

   always_comb begin
      c         = '0;
      c.prow    = req_ch.pixel_row;
      c.pcol    = req_ch.pixel_col;
      c.rh      = req_ch.rect_height;
      c.rw      = req_ch.rect_width;
      c.widx    = req_ch.word_index;
      c.wdata   = req_ch.word_data;
      c.cop     = req_ch.combine_op;
      c.row_in  = DIM_BITS'(req_ch.pixel_row) < rows_ff;
      c.col_in  = DIM_BITS'(req_ch.pixel_col) < cols_ff;
      c.pix_in  = c.row_in && c.col_in;
      c.word_in = (ADDR_BITS + 1)'(req_ch.word_index) < cfg.words;
      c.k       = PIX_BITS'(req_ch.pixel_row * cols_ff + (2*DIM_BITS)'(req_ch.pixel_col));
      c.op      = BK_NONE;
      unique case (req_ch.action)
         ACT_CLEAR_ALL: c.op = BK_CLEAR;
         ACT_FILL_ALL:  c.op = BK_FILL;
         ACT_CLR_PIX: begin
            if (c.pix_in) c.op = BK_PIXCLR;
            else c.ign = 1'b1;
         end
         ACT_SET_PIX: begin
            if (c.pix_in) c.op = BK_PIXSET;
            else c.ign = 1'b1;
         end
         ACT_INVERT:    c.op = BK_INVERT;
         ACT_RECOMPUTE: c.op = BK_RECOMP;
         ACT_COMBINE: begin
            if (!size_ok) begin
               c.ign = 1'b1;
            end else if (c.word_in) begin
               c.op     = BK_COMBINE;
               c.recomp = req_ch.last;
            end else begin
               c.ign = 1'b1;
               if (req_ch.last) c.op = BK_RECOMP;
            end
         end
         ACT_ADD_RECT: begin
            if (!rect_fit) c.ign = 1'b1;
            else if (!rect_empty) c.op = BK_RECT;
         end
         ACT_READ: c.ign = !c.word_in;
         default:  c.ign = 1'b1;
      endcase
   end

   assign req_ch.ready = init_done && !q_full;
   assign push         = req_ch.valid && req_ch.ready;
   assign push_cmd     = c;
endmodule

// ===== rtl/core/pmbe_queue.sv =====
// short command queue between decode and execution
// depends on pmbe_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pmbe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pmbe_pkg::cmd_type push_cmd,
   input  logic              pop,
   output pmbe_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import pmbe_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   cmd_type                   slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]         cnt_ff;

   function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   assign full  = cnt_ff == (PTR_BITS + 1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop) rd_ptr_ff <= bump(rd_ptr_ff);
         cnt_ff <= cnt_ff + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
      end
   end

   `PMBE_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= (PTR_BITS + 1)'(QUEUE_DEPTH), "queue overfilled")
   `PMBE_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, !empty, "pop from empty queue")
   `PMBE_ASSERT_IMP(a_no_push_full, clock, reset, push, !full, "push into full queue")
endmodule

// ===== rtl/core/pmbe_back.sv =====
// execution sequencer: bitmap memory, summaries, walks and result register
// depends on pmbe_pkg, pmbe_if and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pmbe_back (
   input  logic              clock,
   input  logic              reset,
   input  pmbe_pkg::cfg_type cfg,
   input  pmbe_pkg::cmd_type head,
   input  logic              empty,
   output logic              pop,
   output logic              init_done,
   pmbe_rsp_if.source        rsp_ch
);
   import pmbe_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_FILLW, S_INV_RD, S_INV_WR, S_PIX_RD, S_PIX_WR,
      S_CMB_RD, S_CMB_WR, S_RECT_RD, S_RECT_WR, S_REC, S_REC_DRAIN,
      S_FIN_A, S_FIN_B, S_FIN_C
   } state_type;

   state_type              state_ff;
   cmd_type                cmd_ff;
   logic [WORD_BITS-1:0]   mem [MASK_DEPTH];
   logic [WORD_BITS-1:0]   rdata_ff, word_ff, wd;
   logic [ADDR_BITS-1:0]   addr, wi_ff;
   logic                   we;
   logic [MAX_ROWS-1:0]    row_sum_ff, row_fill;
   logic [MAX_COLS-1:0]    col_sum_ff, col_fill, col_rect;
   logic [ROW_BITS-1:0]    rr_ff, p_r_ff, rcur_ff;
   logic [COL_BITS-1:0]    cc_ff, p_c_ff;
   logic [PIX_BITS-1:0]    kk_ff, a_ff, rs_ff;
   logic [4:0]             p_b_ff;
   logic                   pv_ff;
   logic [8:0]             n_ff, left_ff;
   logic [4:0]             off;
   logic [5:0]             room, take;
   logic [WORD_BITS-1:0]   span, pbit, cmb;
   logic                   walk_end, rec_end, rsp_valid_ff;
   logic [WORD_BITS-1:0]   rsp_word_ff;
   logic                   rsp_pix_ff, rsp_row_ff, rsp_col_ff, rsp_ign_ff;

   assign off      = a_ff[4:0];
   assign room     = 6'd32 - {1'b0, off};
   assign take     = ({3'b0, room} > n_ff) ? n_ff[5:0] : room;
   assign span     = (take == 6'd32) ? '1 : (((WORD_BITS'(1) << take) - 1'b1) << off);
   assign pbit     = WORD_BITS'(1) << cmd_ff.k[4:0];
   assign walk_end = (ADDR_BITS + 1)'(wi_ff) == cfg.words - 1'b1;
   assign rec_end  = (DIM_BITS'(rr_ff) == cfg.rows - 1'b1) &&
                     (DIM_BITS'(cc_ff) == cfg.cols - 1'b1);
   assign pop       = (state_ff == S_IDLE) && !empty;
   assign init_done = state_ff != S_INIT;

   always_comb begin
      for (int i = 0; i < MAX_ROWS; i++)
         row_fill[i] = (DIM_BITS'(i >> 5)) < ((cfg.rows + DIM_BITS'(31)) >> 5);
      for (int i = 0; i < MAX_COLS; i++) begin
         col_fill[i] = (DIM_BITS'(i >> 5)) < ((cfg.cols + DIM_BITS'(31)) >> 5);
         col_rect[i] = (10'(i) >= 10'(cmd_ff.pcol)) &&
                       (10'(i) < 10'(cmd_ff.pcol) + 10'(cmd_ff.rw));
      end
   end

   always_comb begin
      unique case (cmd_ff.cop)
         COP_ASSIGN: cmb = cmd_ff.wdata;
         COP_AND:    cmb = rdata_ff & cmd_ff.wdata;
         COP_OR:     cmb = rdata_ff | cmd_ff.wdata;
         COP_XOR:    cmb = rdata_ff ^ cmd_ff.wdata;
         default:    cmb = cmd_ff.wdata;
      endcase
   end

   always_comb begin
      we   = 1'b0;
      addr = '0;
      wd   = '0;
      unique case (state_ff)
         S_INIT: begin
            we   = 1'b1;
            addr = wi_ff;
         end
         S_FILLW: begin
            we   = 1'b1;
            addr = wi_ff;
            wd   = (cmd_ff.op == BK_FILL) ? '1 : '0;
         end
         S_INV_RD: addr = wi_ff;
         S_INV_WR: begin
            we   = 1'b1;
            addr = wi_ff;
            wd   = ~rdata_ff;
         end
         S_PIX_RD: addr = cmd_ff.k[PIX_BITS-1:5];
         S_PIX_WR: begin
            we   = 1'b1;
            addr = cmd_ff.k[PIX_BITS-1:5];
            wd   = (cmd_ff.op == BK_PIXSET) ? (rdata_ff | pbit) : (rdata_ff & ~pbit);
         end
         S_CMB_RD: addr = cmd_ff.widx;
         S_CMB_WR: begin
            we   = 1'b1;
            addr = cmd_ff.widx;
            wd   = cmb;
         end
         S_RECT_RD: addr = a_ff[PIX_BITS-1:5];
         S_RECT_WR: begin
            we   = 1'b1;
            addr = a_ff[PIX_BITS-1:5];
            wd   = rdata_ff | span;
         end
         S_REC:   addr = kk_ff[PIX_BITS-1:5];
         S_FIN_A: addr = cmd_ff.widx;
         S_FIN_B, S_FIN_C: addr = cmd_ff.k[PIX_BITS-1:5];
         default: addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wd;
      rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         wi_ff        <= '0;
         row_sum_ff   <= '0;
         col_sum_ff   <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_FIN_C) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_INIT: begin
               wi_ff <= wi_ff + 1'b1;
               if (wi_ff == ADDR_BITS'(MASK_DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (!empty) begin
                  cmd_ff  <= head;
                  wi_ff   <= '0;
                  a_ff    <= head.k;
                  rs_ff   <= head.k;
                  n_ff    <= head.rw;
                  left_ff <= head.rh;
                  rcur_ff <= head.prow;
                  rr_ff   <= '0;
                  cc_ff   <= '0;
                  kk_ff   <= '0;
                  pv_ff   <= 1'b0;
                  unique case (head.op)
                     BK_NONE:              state_ff <= S_FIN_A;
                     BK_CLEAR, BK_FILL:    state_ff <= S_FILLW;
                     BK_INVERT:            state_ff <= S_INV_RD;
                     BK_PIXCLR, BK_PIXSET: state_ff <= S_PIX_RD;
                     BK_COMBINE:           state_ff <= S_CMB_RD;
                     BK_RECT:              state_ff <= S_RECT_RD;
                     BK_RECOMP: begin
                        row_sum_ff <= '0;
                        col_sum_ff <= '0;
                        state_ff   <= S_REC;
                     end
                     default:              state_ff <= S_FIN_A;
                  endcase
               end
            end
            S_FILLW: begin
               wi_ff <= wi_ff + 1'b1;
               if (walk_end) begin
                  row_sum_ff <= (cmd_ff.op == BK_FILL) ? row_fill : '0;
                  col_sum_ff <= (cmd_ff.op == BK_FILL) ? col_fill : '0;
                  state_ff   <= S_FIN_A;
               end
            end
            S_INV_RD: state_ff <= S_INV_WR;
            S_INV_WR: begin
               wi_ff <= wi_ff + 1'b1;
               if (walk_end) begin
                  row_sum_ff <= '0;
                  col_sum_ff <= '0;
                  state_ff   <= S_REC;
               end else begin
                  state_ff <= S_INV_RD;
               end
            end
            S_PIX_RD: state_ff <= S_PIX_WR;
            S_PIX_WR: state_ff <= S_FIN_A;
            S_CMB_RD: state_ff <= S_CMB_WR;
            S_CMB_WR: begin
               if (cmd_ff.recomp) begin
                  row_sum_ff <= '0;
                  col_sum_ff <= '0;
                  state_ff   <= S_REC;
               end else begin
                  state_ff <= S_FIN_A;
               end
            end
            S_RECT_RD: state_ff <= S_RECT_WR;
            S_RECT_WR: begin
               if (n_ff == 9'(take)) begin
                  row_sum_ff[rcur_ff] <= 1'b1;
                  if (left_ff == 9'd1) begin
                     col_sum_ff <= col_sum_ff | col_rect;
                     state_ff   <= S_FIN_A;
                  end else begin
                     rs_ff    <= PIX_BITS'(rs_ff + cfg.cols);
                     a_ff     <= PIX_BITS'(rs_ff + cfg.cols);
                     n_ff     <= cmd_ff.rw;
                     left_ff  <= left_ff - 1'b1;
                     rcur_ff  <= rcur_ff + 1'b1;
                     state_ff <= S_RECT_RD;
                  end
               end else begin
                  a_ff     <= a_ff + PIX_BITS'(take);
                  n_ff     <= n_ff - 9'(take);
                  state_ff <= S_RECT_RD;
               end
            end
            S_REC: begin
               if (pv_ff && rdata_ff[p_b_ff]) begin
                  row_sum_ff[p_r_ff] <= 1'b1;
                  col_sum_ff[p_c_ff] <= 1'b1;
               end
               pv_ff  <= 1'b1;
               p_r_ff <= rr_ff;
               p_c_ff <= cc_ff;
               p_b_ff <= kk_ff[4:0];
               kk_ff  <= kk_ff + 1'b1;
               if (DIM_BITS'(cc_ff) == cfg.cols - 1'b1) begin
                  cc_ff <= '0;
                  rr_ff <= rr_ff + 1'b1;
               end else begin
                  cc_ff <= cc_ff + 1'b1;
               end
               if (rec_end) state_ff <= S_REC_DRAIN;
            end
            S_REC_DRAIN: begin
               if (pv_ff && rdata_ff[p_b_ff]) begin
                  row_sum_ff[p_r_ff] <= 1'b1;
                  col_sum_ff[p_c_ff] <= 1'b1;
               end
               pv_ff    <= 1'b0;
               state_ff <= S_FIN_A;
            end
            S_FIN_A: state_ff <= S_FIN_B;
            S_FIN_B: begin
               word_ff  <= rdata_ff;
               state_ff <= S_FIN_C;
            end
            S_FIN_C: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= cmd_ff.word_in ? word_ff : '0;
                  rsp_pix_ff   <= cmd_ff.pix_in && rdata_ff[cmd_ff.k[4:0]];
                  rsp_row_ff   <= cmd_ff.row_in && row_sum_ff[cmd_ff.prow];
                  rsp_col_ff   <= cmd_ff.col_in && col_sum_ff[cmd_ff.pcol];
                  rsp_ign_ff   <= cmd_ff.ign;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_word = rsp_word_ff;
   assign rsp_ch.pixel_bit = rsp_pix_ff;
   assign rsp_ch.row_any   = rsp_row_ff;
   assign rsp_ch.col_any   = rsp_col_ff;
   assign rsp_ch.ignored   = rsp_ign_ff;

   `PMBE_ASSERT_IMP(a_walk_index, clock, reset, state_ff == S_REC,
      kk_ff == PIX_BITS'(rr_ff * cfg.cols + (2*DIM_BITS)'(cc_ff)), "pixel walk index drift")
   `PMBE_ASSERT_NXT(a_fin_hold, clock, reset,
      state_ff == S_FIN_C && rsp_valid_ff && !rsp_ch.ready, state_ff == S_FIN_C,
      "result overwritten before taken")
   `PMBE_ASSERT_IMP(a_idle_after_init, clock, reset, pop, init_done,
      "command taken during clearing pass")
endmodule

// ===== rtl/core/pixel_mask_bitmap_engine.sv =====
// top level of the pixel mask bitmap engine
// depends on pmbe_pkg, pmbe_if, pmbe_front, pmbe_queue and pmbe_back
// one request gives one response beat. all bitmap accesses share a single-port word memory,
// which sets the timing: clear_all and fill_all write every word in use, invert reads and
// writes each word in use, add_rect reads and writes each word it touches, and every summary
// rebuild (invert, last combine, recompute) walks all num_rows*num_cols pixels. a held
// response stalls the sequencer. after reset a clearing pass writes all 2048 words before
// the first request is taken; size registers may be written meanwhile. a two-entry queue
// lets requests arrive while one runs.
`timescale 1ns / 1ps
module pixel_mask_bitmap_engine (
   input  logic                              clock,
   input  logic                              reset,
   pmbe_req_if.sink                          req_ch,
   pmbe_rsp_if.source                        rsp_ch,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmbe_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [pmbe_pkg::DIM_BITS-1:0]     csr_data
);
   import pmbe_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd, head;
   logic    push, pop, full, empty, init_done;

   pmbe_front u_front (
      .clock, .reset, .req_ch, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .init_done, .q_full(full), .push, .push_cmd, .cfg
   );

   pmbe_queue u_queue (
      .clock, .reset, .push, .push_cmd, .pop, .head, .full, .empty
   );

   pmbe_back u_back (
      .clock, .reset, .cfg, .head, .empty, .pop, .init_done, .rsp_ch
   );
endmodule
